/* rtl/csac_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csac_pkg
// Types, codes and small helper functions for the clock set and alarm controller.
// ----------------------------------------------------------------------------
package csac_pkg;

    // Input and result beats
    typedef struct packed {
        logic        mode_press;
        logic [15:0] up_held_ticks;
        logic        next_press;
        logic [6:0]  rtc_hours;
        logic [6:0]  rtc_minutes;
        logic [6:0]  rtc_seconds;
        logic [6:0]  rtc_weekday;
        logic [6:0]  rtc_date;
        logic [6:0]  rtc_month;
        logic [6:0]  rtc_year;
    } t_in;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] selected_field;
        logic [7:0] selected_value;
        logic       blank_selected;
        logic       rtc_write_en;
        logic [2:0] rtc_write_field;
        logic [7:0] rtc_write_value;
        logic       alarm_on;
        logic [7:0] alarm_hour;
        logic [7:0] alarm_minute;
    } t_out;

    typedef enum logic [1:0] {
        MODE_INIT   = 2'd0,
        MODE_NORMAL = 2'd1,
        MODE_TIME   = 2'd2,
        MODE_ALARM  = 2'd3
    } t_mode;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_DELAY  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_PERIOD = 1'b1;

    localparam logic [7:0] RESET_REPEAT_DELAY  = 8'd40;
    localparam logic [4:0] RESET_REPEAT_PERIOD = 5'd4;

    // Clock fields that have a real time clock source
    localparam int RTC_FIELDS = 7;
    localparam logic [2:0] FIELD_NO_RTC = 3'd7;

    // Remainder pipeline: held ticks taken four bits per stage
    localparam int HELD_W = 16;
    localparam int NIB_W  = 4;
    localparam int NSTG   = HELD_W / NIB_W + 1;

    localparam logic [3:0] BLINK_LAST  = 4'd9;
    localparam logic [3:0] BLINK_SHOWN = 4'd5;

    typedef struct packed {
        t_in        item;
        logic [4:0] rem;
        logic       up_once;
        logic       rep_ok;
    } t_stg;

    // Four steps of restoring long division, remainder only
    function automatic logic [4:0] rem_steps(input logic [4:0] rem_in,
                                             input logic [NIB_W-1:0] bits,
                                             input logic [4:0] div);
        logic [5:0] acc;
        logic [4:0] r;
        r = rem_in;
        for (int b = NIB_W - 1; b >= 0; b--) begin
            acc = {r, bits[b]};
            if (acc >= {1'b0, div}) begin
                acc = acc - {1'b0, div};
            end
            r = acc[4:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] limit_field(input logic [2:0] idx, input logic [7:0] v);
        logic [7:0] r;
        r = v;
        unique case (idx)
            3'd0: if (v > 8'd24) r = 8'd0;
            3'd1: if (v > 8'd59) r = 8'd0;
            3'd2: if (v > 8'd59) r = 8'd0;
            3'd3: if (v > 8'd8)  r = 8'd2;
            3'd4: if (v > 8'd31) r = 8'd0;
            3'd5: if (v > 8'd12) r = 8'd0;
            3'd6: if (v > 8'd99) r = 8'd0;
            default: r = v;
        endcase
        return r;
    endfunction

    // First press and auto repeat increments, each wrapped by the field limit
    function automatic logic [7:0] bump(input logic [2:0] idx, input logic [7:0] v,
                                        input logic once, input logic rep);
        logic [7:0] r;
        r = v;
        if (once) begin
            r = limit_field(idx, r + 8'd1);
        end
        if (rep) begin
            r = limit_field(idx, r + 8'd1);
        end
        return r;
    endfunction

    function automatic logic [3:0] next_blink(input logic [3:0] c);
        return (c >= BLINK_LAST) ? 4'd0 : c + 4'd1;
    endfunction

endpackage
`default_nettype wire

/* rtl/clock_set_alarm_controller_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clock_set_alarm_controller_core
// Mode, field edit and alarm control for a digital clock, one tick per beat.
// ----------------------------------------------------------------------------
// One input beat is taken per clock cycle when nothing stalls, and each gives
// one result beat. The up-key repeat test needs the held tick count modulo the
// repeat period; that remainder is worked out four bits per stage in a
// five-register pipeline behind the input, and the mode, edit and alarm state
// is then updated in one pass into the result register. The stages close up
// bubbles, so input can still be taken while a result waits to be taken, as
// long as some stage is empty.
// Write the configuration registers only while no beat is in flight.
module clock_set_alarm_controller_core #(
    parameter int NUM_FIELDS = 7
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire  csac_pkg::t_in             i_data,
    output logic                            o_valid,
    input  wire                             i_stall,
    output csac_pkg::t_out                  o_data,
    input  wire                             i_cfg_we,
    input  wire  [csac_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire  [7:0]                      i_cfg_wdata
);
    import csac_pkg::*;

    localparam int SEL_W = $clog2(NUM_FIELDS);
    localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(NUM_FIELDS - 1);

    // Configuration
    logic [7:0] r_repeat_delay;
    logic [4:0] r_repeat_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_delay  <= RESET_REPEAT_DELAY;
            r_repeat_period <= RESET_REPEAT_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_REPEAT_DELAY:  r_repeat_delay  <= i_cfg_wdata;
                CFG_REPEAT_PERIOD: r_repeat_period <= i_cfg_wdata[4:0];
            endcase
        end
    end

    // Remainder pipeline
    t_stg            r_stg [NSTG];
    t_stg            n_stg [NSTG];
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   rdy;
    logic            r_out_vld;
    t_out            r_out;
    logic            fire;

    always_comb begin
        rdy[NSTG] = !r_out_vld || !i_stall;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_stall = !rdy[0];
    assign fire    = r_vld[NSTG-1] && rdy[NSTG];

    always_comb begin
        n_stg[0].item    = i_data;
        n_stg[0].rem     = 5'd0;
        n_stg[0].up_once = (i_data.up_held_ticks == 16'd1);
        n_stg[0].rep_ok  = (r_repeat_period != 5'd0) &&
                           (i_data.up_held_ticks > {8'd0, r_repeat_delay});
        for (int k = 1; k < NSTG; k++) begin
            n_stg[k]     = r_stg[k-1];
            n_stg[k].rem = rem_steps(r_stg[k-1].rem,
                                     r_stg[k-1].item.up_held_ticks[(NSTG-1-k)*NIB_W +: NIB_W],
                                     r_repeat_period);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (rdy[NSTG]) begin
                r_out_vld <= r_vld[NSTG-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r_stg[0] <= n_stg[0];
        end
        for (int k = 1; k < NSTG; k++) begin
            if (rdy[k] && r_vld[k-1]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // Controller state
    t_mode            r_mode, n_mode;
    logic [7:0]       r_time_edit   [NUM_FIELDS];
    logic [7:0]       n_time_edit   [NUM_FIELDS];
    logic [7:0]       r_alarm_edit  [NUM_FIELDS];
    logic [7:0]       n_alarm_edit  [NUM_FIELDS];
    logic [7:0]       r_alarm_store [NUM_FIELDS];
    logic [7:0]       n_alarm_store [NUM_FIELDS];
    logic [SEL_W-1:0] r_time_sel, n_time_sel;
    logic [SEL_W-1:0] r_alarm_sel, n_alarm_sel;
    logic [3:0]       r_time_blink, n_time_blink;
    logic [3:0]       r_alarm_blink, n_alarm_blink;
    logic             r_loaded, n_loaded;
    t_out             n_out;

    t_stg             cur;
    logic [7:0]       rtc_v [8];
    logic             rep;
    logic [SEL_W-1:0] sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_INIT;
            r_time_sel    <= '0;
            r_alarm_sel   <= '0;
            r_time_blink  <= 4'd0;
            r_alarm_blink <= 4'd0;
            r_loaded      <= 1'b0;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                r_time_edit[i]   <= 8'd0;
                r_alarm_edit[i]  <= 8'd0;
                r_alarm_store[i] <= 8'd0;
            end
        end else if (fire) begin
            r_mode        <= n_mode;
            r_time_sel    <= n_time_sel;
            r_alarm_sel   <= n_alarm_sel;
            r_time_blink  <= n_time_blink;
            r_alarm_blink <= n_alarm_blink;
            r_loaded      <= n_loaded;
            r_time_edit   <= n_time_edit;
            r_alarm_edit  <= n_alarm_edit;
            r_alarm_store <= n_alarm_store;
        end
    end

    always_comb begin
        cur      = r_stg[NSTG-1];
        rtc_v[0] = {1'b0, cur.item.rtc_hours};
        rtc_v[1] = {1'b0, cur.item.rtc_minutes};
        rtc_v[2] = {1'b0, cur.item.rtc_seconds};
        rtc_v[3] = {1'b0, cur.item.rtc_weekday};
        rtc_v[4] = {1'b0, cur.item.rtc_date};
        rtc_v[5] = {1'b0, cur.item.rtc_month};
        rtc_v[6] = {1'b0, cur.item.rtc_year};
        rtc_v[7] = 8'd0;
        rep      = cur.rep_ok && (cur.rem == 5'd1);

        n_mode        = r_mode;
        n_time_edit   = r_time_edit;
        n_alarm_edit  = r_alarm_edit;
        n_alarm_store = r_alarm_store;
        n_time_sel    = r_time_sel;
        n_alarm_sel   = r_alarm_sel;
        n_time_blink  = r_time_blink;
        n_alarm_blink = r_alarm_blink;
        n_loaded      = r_loaded;
        n_out         = '0;
        sel           = '0;

        unique case (r_mode)
            MODE_INIT: begin
                n_mode = MODE_NORMAL;
            end
            MODE_NORMAL: begin
                n_time_sel  = '0;
                n_alarm_sel = '0;
                for (int i = 0; i < NUM_FIELDS; i++) begin
                    n_time_edit[i]  = 8'd0;
                    n_alarm_edit[i] = 8'd0;
                end
                n_out.alarm_on = (rtc_v[0] == r_alarm_store[0]) &&
                                 (rtc_v[1] == r_alarm_store[1]);
                if (cur.item.mode_press) begin
                    n_mode = MODE_TIME;
                end
            end
            MODE_TIME: begin
                // Fill empty edit fields from the clock on the first tick
                if (!r_loaded) begin
                    for (int i = 0; i < NUM_FIELDS; i++) begin
                        if (i < RTC_FIELDS && r_time_edit[i] == 8'd0) begin
                            n_time_edit[i] = rtc_v[i];
                        end
                    end
                end
                n_loaded             = 1'b1;
                n_time_blink         = next_blink(r_time_blink);
                n_out.blank_selected = (n_time_blink > BLINK_SHOWN);
                sel                  = r_time_sel;
                n_time_edit[sel]     = bump(3'(sel), n_time_edit[sel], cur.up_once, rep);
                if (cur.item.next_press) begin
                    if (3'(sel) != FIELD_NO_RTC) begin
                        n_out.rtc_write_en    = 1'b1;
                        n_out.rtc_write_field = 3'(sel);
                        n_out.rtc_write_value = n_time_edit[sel];
                    end
                    n_time_sel = (sel == SEL_LAST) ? '0 : sel + 1'b1;
                end
                n_out.selected_field = 3'(n_time_sel);
                n_out.selected_value = n_time_edit[n_time_sel];
                if (cur.item.mode_press) begin
                    n_loaded = 1'b0;
                    n_mode   = MODE_ALARM;
                end
            end
            MODE_ALARM: begin
                // Fill empty edit fields from the stored alarm on the first tick
                if (!r_loaded) begin
                    for (int i = 0; i < NUM_FIELDS; i++) begin
                        if (r_alarm_edit[i] == 8'd0) begin
                            n_alarm_edit[i] = r_alarm_store[i];
                        end
                    end
                end
                n_loaded             = 1'b1;
                n_alarm_blink        = next_blink(r_alarm_blink);
                n_out.blank_selected = (n_alarm_blink > BLINK_SHOWN);
                sel                  = r_alarm_sel;
                n_alarm_edit[sel]    = bump(3'(sel), n_alarm_edit[sel], cur.up_once, rep);
                if (cur.item.next_press) begin
                    if (3'(sel) != FIELD_NO_RTC) begin
                        n_alarm_store[sel] = n_alarm_edit[sel];
                    end
                    n_alarm_sel = (sel == SEL_LAST) ? '0 : sel + 1'b1;
                end
                n_out.selected_field = 3'(n_alarm_sel);
                n_out.selected_value = n_alarm_edit[n_alarm_sel];
                if (cur.item.mode_press) begin
                    n_loaded = 1'b0;
                    n_mode   = MODE_NORMAL;
                end
            end
        endcase

        n_out.mode         = n_mode;
        n_out.alarm_hour   = n_alarm_store[0];
        n_out.alarm_minute = n_alarm_store[1];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule
`default_nettype wire

/* tb/csac_tick_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csac_tick_checker
// Watches the tick and result channels of the clock set and alarm controller,
// keeps its own copy of the mode, edit, alarm and blink state and of the two
// repeat registers, predicts one result per accepted tick and compares every
// accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module csac_tick_checker #(
    parameter int NUM_FIELDS = 7
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    input  wire                             i_in_stall,
    input  csac_pkg::t_in                   i_in_data,
    input  wire                             i_out_valid,
    input  wire                             i_out_stall,
    input  csac_pkg::t_out                  i_out_data,
    input  wire                             i_cfg_we,
    input  wire  [csac_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire  [7:0]                      i_cfg_wdata,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_alarm_hits,
    output int                              o_clock_writes
);
    import csac_pkg::*;

    localparam logic [2:0] FLD_HOUR    = 3'd0;
    localparam logic [2:0] FLD_MIN     = 3'd1;
    localparam logic [2:0] FLD_SEC     = 3'd2;
    localparam logic [2:0] FLD_WEEKDAY = 3'd3;
    localparam logic [2:0] FLD_DATE    = 3'd4;
    localparam logic [2:0] FLD_MONTH   = 3'd5;
    localparam logic [2:0] FLD_YEAR    = 3'd6;
    localparam int         MAX_REPORTS = 30;

    logic [7:0] rep_delay;
    logic [4:0] rep_period;
    t_mode      mode_q;
    logic [7:0] time_edit [8];
    logic [7:0] alarm_edit [8];
    logic [7:0] alarm_store [8];
    logic [2:0] time_sel;
    logic [2:0] alarm_sel;
    logic [3:0] time_blink;
    logic [3:0] alarm_blink;
    logic       loaded;
    t_out       tick_results_due [$];

    function automatic logic [7:0] wrap_field(input logic [2:0] idx, input logic [7:0] v);
        case (idx)
            FLD_HOUR:         return (v > 8'd24) ? 8'd0 : v;
            FLD_MIN, FLD_SEC: return (v > 8'd59) ? 8'd0 : v;
            FLD_WEEKDAY:      return (v > 8'd8)  ? 8'd2 : v;
            FLD_DATE:         return (v > 8'd31) ? 8'd0 : v;
            FLD_MONTH:        return (v > 8'd12) ? 8'd0 : v;
            FLD_YEAR:         return (v > 8'd99) ? 8'd0 : v;
            default:          return v;
        endcase
    endfunction

    // First press, then auto repeat; both can land on the same tick
    function automatic logic [7:0] press_up(input logic [2:0] idx, input logic [7:0] v,
                                            input logic [15:0] held);
        logic [7:0] r;
        r = v;
        if (held == 16'd1) begin
            r = wrap_field(idx, r + 8'd1);
        end
        if (rep_period != 5'd0 && held > {8'd0, rep_delay} &&
            (int'(held) % int'(rep_period)) == 1) begin
            r = wrap_field(idx, r + 8'd1);
        end
        return r;
    endfunction

    function automatic logic [2:0] following_field(input logic [2:0] s);
        return (int'(s) + 1 >= NUM_FIELDS) ? 3'd0 : s + 3'd1;
    endfunction

    // Advance the mirrored state by one tick and return the result it gives
    function automatic t_out predict_tick(input t_in b);
        t_out       r;
        logic [7:0] rtc [7];
        logic [2:0] s;
        r = '0;
        rtc[0] = {1'b0, b.rtc_hours};
        rtc[1] = {1'b0, b.rtc_minutes};
        rtc[2] = {1'b0, b.rtc_seconds};
        rtc[3] = {1'b0, b.rtc_weekday};
        rtc[4] = {1'b0, b.rtc_date};
        rtc[5] = {1'b0, b.rtc_month};
        rtc[6] = {1'b0, b.rtc_year};
        case (mode_q)
            MODE_INIT: begin
                mode_q = MODE_NORMAL;
            end
            MODE_NORMAL: begin
                time_sel  = 3'd0;
                alarm_sel = 3'd0;
                for (int i = 0; i < NUM_FIELDS && i < 8; i++) begin
                    time_edit[i]  = 8'd0;
                    alarm_edit[i] = 8'd0;
                end
                r.alarm_on = (rtc[0] == alarm_store[0]) && (rtc[1] == alarm_store[1]);
                if (b.mode_press) begin
                    mode_q = MODE_TIME;
                end
            end
            MODE_TIME: begin
                if (!loaded) begin
                    for (int i = 0; i < NUM_FIELDS && i < RTC_FIELDS; i++) begin
                        if (time_edit[i] == 8'd0) time_edit[i] = rtc[i];
                    end
                end
                loaded = 1'b1;
                time_blink = (time_blink >= BLINK_LAST) ? 4'd0 : time_blink + 4'd1;
                r.blank_selected = (time_blink > BLINK_SHOWN);
                time_edit[time_sel] = press_up(time_sel, time_edit[time_sel], b.up_held_ticks);
                if (b.next_press) begin
                    s = time_sel;
                    if (s < FIELD_NO_RTC) begin
                        r.rtc_write_en    = 1'b1;
                        r.rtc_write_field = s;
                        r.rtc_write_value = time_edit[s];
                    end
                    time_sel = following_field(s);
                end
                r.selected_field = time_sel;
                r.selected_value = time_edit[time_sel];
                if (b.mode_press) begin
                    loaded = 1'b0;
                    mode_q = MODE_ALARM;
                end
            end
            default: begin
                if (!loaded) begin
                    for (int i = 0; i < NUM_FIELDS && i < 8; i++) begin
                        if (alarm_edit[i] == 8'd0) alarm_edit[i] = alarm_store[i];
                    end
                end
                loaded = 1'b1;
                alarm_blink = (alarm_blink >= BLINK_LAST) ? 4'd0 : alarm_blink + 4'd1;
                r.blank_selected = (alarm_blink > BLINK_SHOWN);
                alarm_edit[alarm_sel] = press_up(alarm_sel, alarm_edit[alarm_sel],
                                                 b.up_held_ticks);
                if (b.next_press) begin
                    s = alarm_sel;
                    if (s < FIELD_NO_RTC) alarm_store[s] = alarm_edit[s];
                    alarm_sel = following_field(s);
                end
                r.selected_field = alarm_sel;
                r.selected_value = alarm_edit[alarm_sel];
                if (b.mode_press) begin
                    loaded = 1'b0;
                    mode_q = MODE_NORMAL;
                end
            end
        endcase
        r.mode         = mode_q;
        r.alarm_hour   = alarm_store[0];
        r.alarm_minute = alarm_store[1];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            if (o_errors < MAX_REPORTS) begin
                $display("%0t ns: result %0d, %s expected %0d, got %0d",
                         $time, o_checked, name, want, got);
            end
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            rep_delay   = RESET_REPEAT_DELAY;
            rep_period  = RESET_REPEAT_PERIOD;
            mode_q      = MODE_INIT;
            time_sel    = 3'd0;
            alarm_sel   = 3'd0;
            time_blink  = 4'd0;
            alarm_blink = 4'd0;
            loaded      = 1'b0;
            for (int i = 0; i < 8; i++) begin
                time_edit[i]   = 8'd0;
                alarm_edit[i]  = 8'd0;
                alarm_store[i] = 8'd0;
            end
            tick_results_due.delete();
            o_errors       = 0;
            o_checked      = 0;
            o_alarm_hits   = 0;
            o_clock_writes = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_REPEAT_DELAY) rep_delay = i_cfg_wdata;
                else rep_period = i_cfg_wdata[4:0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (tick_results_due.size() == 0) begin
                    if (o_errors < MAX_REPORTS) begin
                        $display("%0t ns: result beat with no tick outstanding, got %h",
                                 $time, i_out_data);
                    end
                    o_errors++;
                end else begin
                    want = tick_results_due.pop_front();
                    check_field("mode", want.mode, i_out_data.mode);
                    check_field("selected_field", want.selected_field,
                                i_out_data.selected_field);
                    check_field("selected_value", want.selected_value,
                                i_out_data.selected_value);
                    check_field("blank_selected", want.blank_selected,
                                i_out_data.blank_selected);
                    check_field("rtc_write_en", want.rtc_write_en, i_out_data.rtc_write_en);
                    check_field("rtc_write_field", want.rtc_write_field,
                                i_out_data.rtc_write_field);
                    check_field("rtc_write_value", want.rtc_write_value,
                                i_out_data.rtc_write_value);
                    check_field("alarm_on", want.alarm_on, i_out_data.alarm_on);
                    check_field("alarm_hour", want.alarm_hour, i_out_data.alarm_hour);
                    check_field("alarm_minute", want.alarm_minute, i_out_data.alarm_minute);
                    o_checked++;
                    if (want.alarm_on) o_alarm_hits++;
                    if (want.rtc_write_en) o_clock_writes++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                tick_results_due.push_back(predict_tick(i_in_data));
            end
        end
        o_pending = tick_results_due.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the clock set and alarm controller: a directed walk
// through the modes and field limits, then random key sessions under several
// repeat settings and idling patterns, checked by csac_tick_checker.
// ----------------------------------------------------------------------------
module testbench;
    import csac_pkg::*;

    localparam int         NUM_FIELDS      = 7;
    localparam int         RESET_CYCLES    = 5;
    localparam int         STALL_LIMIT     = 2000;
    localparam int         RANDOM_PHASES   = 6;
    localparam int         PHASE_BEATS     = 205;
    localparam int         HOLD_OFF_CYCLES = 150;
    localparam int         SETTLE_CYCLES   = 12;
    localparam logic [6:0] RTC_TOP         = 7'd99;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_in                   i_data;
    logic                  o_valid;
    logic                  i_stall;
    t_out                  o_data;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [7:0]            i_cfg_wdata;

    int errors;
    int pending;
    int checked;
    int alarm_hits;
    int clock_writes;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_start;
    int idle_cycles;

    clock_set_alarm_controller_core #(.NUM_FIELDS(NUM_FIELDS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    csac_tick_checker #(.NUM_FIELDS(NUM_FIELDS)) tick_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_in_data     (i_data),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_data    (o_data),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_alarm_hits  (alarm_hits),
        .o_clock_writes(clock_writes)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result side: random stall, or a long hold-off when asked for one
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_start) begin
                hold_start = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_in tick(input logic mode_k, input logic [15:0] held,
                                 input logic next_k, input logic [6:0] hr,
                                 input logic [6:0] mi, input logic [6:0] se,
                                 input logic [6:0] wd, input logic [6:0] dt,
                                 input logic [6:0] mo, input logic [6:0] yr);
        t_in b;
        b.mode_press    = mode_k;
        b.up_held_ticks = held;
        b.next_press    = next_k;
        b.rtc_hours     = hr;
        b.rtc_minutes   = mi;
        b.rtc_seconds   = se;
        b.rtc_weekday   = wd;
        b.rtc_date      = dt;
        b.rtc_month     = mo;
        b.rtc_year      = yr;
        return b;
    endfunction

    // Called and returning at a falling edge
    task automatic send_tick(input t_in d);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_in         b;
        logic [15:0] held_now;
        int          hold_left;
        int          pick;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        hold_start    = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 65;
        held_now      = 16'd0;
        hold_left     = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk at the reset repeat settings
        send_tick(tick(1'b0, 16'd0, 1'b0, 0, 0, 0, 0, 0, 0, 0));
        // normal: clock equals the empty alarm store
        send_tick(tick(1'b0, 16'd0, 1'b0, 0, 0, 0, 0, 0, 0, 0));
        // keys have no effect outside the set modes
        send_tick(tick(1'b0, 16'd1, 1'b1, RTC_TOP, RTC_TOP, RTC_TOP, RTC_TOP, RTC_TOP,
                       RTC_TOP, RTC_TOP));
        send_tick(tick(1'b1, 16'd0, 1'b0, RTC_TOP, RTC_TOP, RTC_TOP, RTC_TOP, RTC_TOP,
                       RTC_TOP, RTC_TOP));
        // set time: load every field at its top value
        send_tick(tick(1'b0, 16'd0, 1'b0, RTC_TOP, RTC_TOP, RTC_TOP, RTC_TOP, RTC_TOP,
                       RTC_TOP, RTC_TOP));
        // hour past its limit, then repeat, no repeat and repeat again
        send_tick(tick(1'b0, 16'd1, 1'b0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick(1'b0, 16'd41, 1'b0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick(1'b0, 16'hFFFF, 1'b0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick(1'b0, 16'd45, 1'b0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick(1'b0, 16'd0, 1'b1, 0, 0, 0, 0, 0, 0, 0));
        // bump every other field past its limit and commit it, wrapping the selection
        for (int k = 0; k < RTC_FIELDS - 1; k++) begin
            send_tick(tick(1'b0, 16'd1, 1'b1, 0, 0, 0, 0, 0, 0, 0));
        end
        // commit and leave on the same tick
        send_tick(tick(1'b1, 16'd0, 1'b1, 0, 0, 0, 0, 0, 0, 0));
        // set alarm to 2:01
        send_tick(tick(1'b0, 16'd1, 1'b0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick(1'b0, 16'd1, 1'b1, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick(1'b0, 16'd1, 1'b1, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick(1'b1, 16'd0, 1'b0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick(1'b0, 16'd0, 1'b0, 7'd2, 7'd1, 0, 0, 0, 0, 0));
        // enter set time with a zero clock, then pass straight through
        send_tick(tick(1'b1, 16'd0, 1'b0, 7'd2, 7'd1, 0, 0, 0, 0, 0));
        send_tick(tick(1'b0, 16'd0, 1'b0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick(1'b1, 16'd0, 1'b0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick(1'b1, 16'd0, 1'b0, 0, 0, 0, 0, 0, 0, 0));

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    // first press and repeat can coincide
                    write_reg(CFG_REPEAT_DELAY, 8'd0);
                    write_reg(CFG_REPEAT_PERIOD, 8'd4);
                end
                1: begin
                    write_reg(CFG_REPEAT_DELAY, 8'd255);
                    write_reg(CFG_REPEAT_PERIOD, 8'd16);
                end
                2: begin
                    write_reg(CFG_REPEAT_DELAY, 8'd0);
                    write_reg(CFG_REPEAT_PERIOD, 8'd1);
                end
                3: begin
                    write_reg(CFG_REPEAT_PERIOD, 8'd0);
                end
                4: begin
                    write_reg(CFG_REPEAT_DELAY, 8'($urandom_range(60)));
                    write_reg(CFG_REPEAT_PERIOD, 8'($urandom_range(16, 2)));
                end
                default: begin
                    write_reg(CFG_REPEAT_DELAY, RESET_REPEAT_DELAY);
                    write_reg(CFG_REPEAT_PERIOD, {3'd0, RESET_REPEAT_PERIOD});
                end
            endcase
            if (phase < 2) begin
                send_idle_pct = 10;
                recv_idle_pct = 65;
            end else if (phase < 4) begin
                send_idle_pct = 65;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if ((phase == 1 || phase == 4) && n == 60) hold_start = 1'b1;
                if ($urandom_range(99) < 10) begin
                    // noise: any held count, any keys
                    b = tick(1'($urandom_range(1)), 16'($urandom_range(65535)),
                             1'($urandom_range(1)), 7'($urandom_range(99)),
                             7'($urandom_range(99)), 7'($urandom_range(99)),
                             7'($urandom_range(99)), 7'($urandom_range(99)),
                             7'($urandom_range(99)), 7'($urandom_range(99)));
                end else begin
                    // a user on the keys: press, hold for a while, release
                    if (hold_left > 0) begin
                        held_now++;
                        hold_left--;
                    end else if (held_now != 16'd0) begin
                        held_now = 16'd0;
                    end else if ($urandom_range(99) < 35) begin
                        pick = $urandom_range(99);
                        if (pick < 70) hold_left = $urandom_range(4);
                        else if (pick < 95) hold_left = $urandom_range(60);
                        else hold_left = $urandom_range(320);
                        held_now = 16'd1;
                    end
                    // small hours and minutes make alarm matches likely
                    b = tick($urandom_range(99) < 3, held_now, $urandom_range(99) < 12,
                             7'($urandom_range(1) ? $urandom_range(3) : $urandom_range(99)),
                             7'($urandom_range(1) ? $urandom_range(3) : $urandom_range(99)),
                             7'($urandom_range(99)), 7'($urandom_range(99)),
                             7'($urandom_range(99)), 7'($urandom_range(99)),
                             7'($urandom_range(99)));
                end
                send_tick(b);
            end
        end

        wait_drained();
        $display("Ran %0d ticks through directed mode walks and %0d repeat settings,",
                 checked, RANDOM_PHASES + 1);
        $display("with %0d clock field writes, %0d alarm matches and long result hold-offs.",
                 clock_writes, alarm_hits);
        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
